// ===== design/dcl_pkg.sv =====
// Shared types and constants for the dominance chain length unit.
// No dependencies; imported by every design module.
package dcl_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned LenW   = 11;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic        [LenW-1:0]   len_t;

  localparam len_t LenMax = {LenW{1'b1}};
  localparam len_t LenOne = len_t'(1);

  // one stored point and its chain length
  typedef struct packed {
    coord_t x;
    coord_t y;
    len_t   len;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // read and write request toward the point store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } store_ctl_t;

endpackage

// ===== design/dcl_store.sv =====
// Point store: one write port and one read port with registered read data.
// Depends on dcl_pkg for the entry type.
module dcl_store #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic              clk_i,
  input  dcl_pkg::store_ctl_t ctl_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  dcl_pkg::entry_t   wdata_i,
  input  logic [AddrW-1:0]  raddr_i,
  output dcl_pkg::entry_t   rdata_o
);
  import dcl_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/dcl_scan.sv =====
// Shared compare unit: tests one stored entry a cycle, while hit_valid_i is set, against the current
// point and keeps the largest qualifying length. Depends on dcl_pkg.
module dcl_scan (
  input  logic            clk_i,
  input  logic            clr_i,
  input  logic            hit_valid_i,
  input  dcl_pkg::entry_t entry_i,
  input  dcl_pkg::coord_t px_i,
  input  dcl_pkg::coord_t py_i,
  output dcl_pkg::len_t   len_o
);
  import dcl_pkg::*;

  len_t   top_q, top_d;
  coord_t sx, sy;
  logic   hit;

  always_comb begin
    sx  = $signed(entry_i.x);
    sy  = $signed(entry_i.y);
    // stored point must sit inside [1, p] on both axes
    hit = (sx >= coord_t'(1)) && (sx <= px_i) &&
          (sy >= coord_t'(1)) && (sy <= py_i) &&
          (entry_i.len > top_q);
    top_d = top_q;
    if (clr_i) begin
      top_d = '0;
    end else if (hit_valid_i && hit) begin
      top_d = entry_i.len;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

  // saturating increment
  assign len_o = (top_q == LenMax) ? LenMax : top_q + LenOne;

endmodule

// ===== design/dominance_chain_length_unit.sv =====
// Dominance chain length unit. Each accepted point (x, y) is compared with every
// point stored in the current set; its chain length is one more than the largest
// length among stored points with 1 <= x' <= x and 1 <= y' <= y, and the point is
// then stored. Each point scans the stored set through the single read port of the
// point store, one entry a cycle; the input stalls while a point is being processed.
// start_new empties the set. Once MAX_POINTS points are held, results are still
// given but the point is dropped and store_full is set. A finished result may wait
// in the output register while the next point is accepted. No clearing pass is
// needed.
module dominance_chain_length_unit #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dcl_pkg::coord_t     point_x_i,
  input  dcl_pkg::coord_t     point_y_i,
  input  logic                start_new_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dcl_pkg::len_t       chain_length_o,
  output dcl_pkg::len_t       longest_so_far_o,
  output logic                store_full_o
);
  import dcl_pkg::*;

  localparam int unsigned AddrW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_POINTS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_POINTS);

  state_e          state_q, state_d;
  coord_t          px_q, px_d, py_q, py_d;
  logic [CntW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  len_t            best_q, best_d;
  logic            rd_pend_q, rd_pend_d;
  logic            out_valid_q, out_valid_d;
  len_t            out_len_q, out_len_d, out_best_q, out_best_d;
  logic            out_full_q, out_full_d;

  store_ctl_t      ctl;
  entry_t          wdata, rdata;
  len_t            len;
  logic            accept, clr, full;

  assign accept = in_valid_i && !in_stall_o;
  assign clr    = accept;
  assign full   = (cnt_q == CntMax);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      best_q      <= '0;
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      best_q      <= best_d;
      idx_q       <= idx_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q       <= px_d;
    py_q       <= py_d;
    out_len_q  <= out_len_d;
    out_best_q <= out_best_d;
    out_full_q <= out_full_d;
  end

  always_comb begin
    state_d     = state_q;
    px_d        = px_q;
    py_d        = py_q;
    cnt_d       = cnt_q;
    best_d      = best_q;
    idx_d       = idx_q;
    rd_pend_d   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_len_d   = out_len_q;
    out_best_d  = out_best_q;
    out_full_d  = out_full_q;
    ctl         = '0;
    in_stall_o  = (state_q != ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          px_d  = point_x_i;
          py_d  = point_y_i;
          idx_d = '0;
          if (start_new_i) begin
            cnt_d  = '0;
            best_d = '0;
          end
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl.rd_en = (idx_q < cnt_q);
        rd_pend_d = ctl.rd_en;
        if (ctl.rd_en) begin
          idx_d = idx_q + CntW'(1);
        end else if (!rd_pend_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          ctl.wr_en   = !full;
          if (!full) begin
            cnt_d = cnt_q + CntW'(1);
          end
          best_d      = (len > best_q) ? len : best_q;
          out_valid_d = 1'b1;
          out_len_d   = len;
          out_best_d  = (len > best_q) ? len : best_q;
          out_full_d  = full;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign wdata = '{x: px_q, y: py_q, len: len};

  dcl_store #(
    .Depth (MAX_POINTS),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (wdata),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  dcl_scan u_scan (
    .clk_i       (clk_i),
    .clr_i       (clr),
    .hit_valid_i (rd_pend_q),
    .entry_i     (rdata),
    .px_i        (px_q),
    .py_i        (py_q),
    .len_o       (len)
  );

  assign out_valid_o      = out_valid_q;
  assign chain_length_o   = out_len_q;
  assign longest_so_far_o = out_best_q;
  assign store_full_o     = out_full_q;

endmodule

// ===== design/dcl_checker.sv =====
// Port-level checks for the dominance chain length unit, with the bind that
// attaches them to the top level. Depends on dcl_pkg.
module dcl_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input dcl_pkg::len_t chain_length_o,
  input dcl_pkg::len_t longest_so_far_o,
  input logic          store_full_o
);
  import dcl_pkg::*;

  // a chain always contains at least the point itself
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (chain_length_o != '0))
    else $error("chain_length_o is zero");

  // the running best covers the current point
  a_best_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (longest_so_far_o >= chain_length_o))
    else $error("longest_so_far_o below chain_length_o");

  // the unit is busy right after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepted transaction");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(chain_length_o) && $stable(longest_so_far_o) &&
       $stable(store_full_o)))
    else $error("stalled result changed");

endmodule

bind dominance_chain_length_unit dcl_checker u_dcl_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for dominance_chain_length_unit.
// Needs dcl_pkg and the unit; a built-in chain predictor, or a typed row expectation, checks every result.
`timescale 1ns / 1ps

module testbench;
  import dcl_pkg::*;

  localparam int unsigned MaxPoints  = 1024;
  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned DrainWait  = MaxPoints + 100;
  localparam coord_t      CoordMin   = 32'sh8000_0000;
  localparam coord_t      CoordMax   = 32'sh7fff_ffff;

  typedef struct packed {
    len_t chain;
    len_t best;
    logic full;
  } chain_result_t;

  typedef struct packed {
    coord_t        x;
    coord_t        y;
    logic          start;
    logic          typed;
    chain_result_t res;
  } point_row_t;

  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  logic   in_stall_o;
  coord_t point_x_i   = '0;
  coord_t point_y_i   = '0;
  logic   start_new_i = 1'b0;
  logic   out_valid_o;
  logic   out_stall_i = 1'b0;
  len_t   chain_length_o;
  len_t   longest_so_far_o;
  logic   store_full_o;

  // typed expectation riding along with the driven transaction
  logic          row_typed = 1'b0;
  chain_result_t row_result = '0;

  // predictor copy of the point store
  coord_t      pred_x [MaxPoints];
  coord_t      pred_y [MaxPoints];
  len_t        pred_len [MaxPoints];
  int unsigned pred_count = 0;
  len_t        pred_best = '0;

  chain_result_t pending_results [$];
  point_row_t    directed_rows [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned points_sent = 0;
  int unsigned sets_sent = 0;
  int unsigned results_checked = 0;
  int unsigned full_seen = 0;

  dominance_chain_length_unit #(
    .MAX_POINTS(MaxPoints)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .start_new_i     (start_new_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .chain_length_o  (chain_length_o),
    .longest_so_far_o(longest_so_far_o),
    .store_full_o    (store_full_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic chain_result_t next_chain(coord_t x, coord_t y, logic start);
    chain_result_t res;
    len_t          top;
    top = '0;
    if (start) begin
      pred_count = 0;
      pred_best  = '0;
    end
    // only stored points inside the window at or above 1 count
    for (int unsigned i = 0; i < pred_count; i++) begin
      if (pred_x[i] >= 1 && pred_x[i] <= x && pred_y[i] >= 1 && pred_y[i] <= y &&
          pred_len[i] > top)
        top = pred_len[i];
    end
    res.chain = (top == LenMax) ? LenMax : top + LenOne;
    res.full  = (pred_count >= MaxPoints);
    if (!res.full) begin
      pred_x[pred_count]   = x;
      pred_y[pred_count]   = y;
      pred_len[pred_count] = res.chain;
      pred_count++;
    end
    if (res.chain > pred_best)
      pred_best = res.chain;
    res.best = pred_best;
    return res;
  endfunction

  task automatic report_error(string msg);
    error_count++;
    if (error_count <= 10)
      $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // predicts on input transactions and checks output transactions
  always @(posedge clk_i) begin
    chain_result_t exp_res;
    chain_result_t got;
    if (rst_ni) begin
      if (in_valid_i && in_stall_o === 1'b0) begin
        exp_res = next_chain(point_x_i, point_y_i, start_new_i);
        if (row_typed)
          exp_res = row_result;
        pending_results.insert(pending_results.size(), exp_res);
      end
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        got = '{chain: chain_length_o, best: longest_so_far_o, full: store_full_o};
        results_checked++;
        if (got.full === 1'b1)
          full_seen++;
        if (pending_results.size() == 0) begin
          report_error($sformatf("result with nothing expected: len %0d best %0d full %0b",
                                 got.chain, got.best, got.full));
        end else begin
          exp_res = pending_results.pop_front();
          if (got.chain !== exp_res.chain || got.best !== exp_res.best ||
              got.full !== exp_res.full)
            report_error($sformatf(
                "result %0d: expected len %0d best %0d full %0b, got len %0d best %0d full %0b",
                results_checked, exp_res.chain, exp_res.best, exp_res.full,
                got.chain, got.best, got.full));
        end
      end
    end
  end

  task automatic send_point(coord_t x, coord_t y, logic start, logic typed,
                            chain_result_t res);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i  <= 1'b1;
    point_x_i   <= x;
    point_y_i   <= y;
    start_new_i <= start;
    row_typed   <= typed;
    row_result  <= res;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    points_sent++;
    if (start)
      sets_sent++;
  endtask

  function automatic void add_row(coord_t x, coord_t y, logic start, logic typed,
                                  int unsigned chain, int unsigned best, logic full);
    point_row_t row;
    row.x     = x;
    row.y     = y;
    row.start = start;
    row.typed = typed;
    row.res   = '{chain: len_t'(chain), best: len_t'(best), full: full};
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // ramp coordinates build long chains; the rest mixes small, extreme and wide values
  function automatic coord_t pick_coord(int k, bit ramp);
    int unsigned sel;
    sel = $urandom_range(15);
    if (ramp && sel < 10)
      return coord_t'(k + int'($urandom_range(3)) - 1);
    if (sel < 9)
      return coord_t'(int'($urandom_range(24)) - 2);
    if (sel < 12)
      return coord_t'($urandom);
    case ($urandom_range(4))
      0:       return CoordMin;
      1:       return CoordMax;
      2:       return coord_t'(0);
      3:       return coord_t'(1);
      default: return coord_t'(-1);
    endcase
  endfunction

  task automatic run_random(int unsigned count);
    int unsigned done;
    int unsigned set_size;
    bit          ramp;
    done = 0;
    while (done < count) begin
      case ($urandom_range(9))
        0:       set_size = 1;
        8, 9:    set_size = $urandom_range(60, 25);
        default: set_size = $urandom_range(24, 2);
      endcase
      ramp = $urandom_range(1);
      for (int unsigned k = 0; k < set_size && done < count; k++) begin
        // occasional restart in the middle of a set
        send_point(pick_coord(k, ramp), pick_coord(k, ramp),
                   (k == 0) || ($urandom_range(99) < 3), 1'b0, '0);
        done++;
      end
    end
  endtask

  initial begin
    add_row(5, 5, 1, 1, 1, 1, 0);
    add_row(5, 5, 0, 1, 2, 2, 0);          // equal coordinates count
    add_row(0, 100, 0, 1, 1, 2, 0);
    add_row(100, 100, 0, 0, 0, 0, 0);
    add_row(CoordMin, CoordMin, 0, 1, 1, 3, 0);
    add_row(CoordMax, CoordMax, 0, 0, 0, 0, 0);
    add_row(CoordMax, 0, 0, 0, 0, 0, 0);
    add_row(1, 1, 0, 0, 0, 0, 0);
    add_row(1, 1, 0, 0, 0, 0, 0);
    add_row(-1, 7, 0, 0, 0, 0, 0);         // new point below the window
    add_row(7, -1, 0, 0, 0, 0, 0);
    add_row(3, CoordMax, 0, 0, 0, 0, 0);
    add_row(CoordMax, CoordMax, 1, 1, 1, 1, 0);
    add_row(0, 0, 0, 1, 1, 1, 0);
    add_row(1, 1, 0, 0, 0, 0, 0);          // stored (0,0) lies outside the window
    add_row(CoordMin, CoordMax, 0, 0, 0, 0, 0);
    add_row(CoordMax, CoordMin, 0, 0, 0, 0, 0);
    add_row(2, 2, 0, 0, 0, 0, 0);
    add_row(-5, -5, 1, 1, 1, 1, 0);
    add_row(-5, -5, 0, 1, 1, 1, 0);
    add_row(CoordMax, 1, 0, 0, 0, 0, 0);
    add_row(1, CoordMax, 0, 0, 0, 0, 0);
    add_row(CoordMax, CoordMax, 0, 0, 0, 0, 0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 11;
    recv_idle_pct = 55;
    foreach (directed_rows[i])
      send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].start,
                 directed_rows[i].typed, directed_rows[i].res);
    run_random(200);

    send_idle_pct = 55;
    recv_idle_pct = 11;
    run_random(200);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(160);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (pending_results.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_results.size()));
    $display("%0d points in %0d sets, %0d results checked, %0d with the store full",
             points_sent, sets_sent, results_checked, full_seen);
    $display("%0d mismatches in %0d cycles", error_count, cycle_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== dominance_chain_length_unit.f =====
design/dcl_pkg.sv
design/dcl_store.sv
design/dcl_scan.sv
design/dominance_chain_length_unit.sv
design/dcl_checker.sv
sim/testbench.sv
